FILE: design/sbmq_pkg.sv
`timescale 1ns / 1ps
// Package for the shared-buffer multi-queue manager.
// Holds the default sizes, the command and status codes and the transfer structs.
package sbmq_pkg;

	localparam int SLOTS_DEF      = 256;
	localparam int QUEUES_DEF     = 8;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t               command;
		logic [2:0]         queue_id;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] data_out;
		status_t            status;
		logic               queue_empty;
		logic               store_full;
	} rsp_t;

endpackage

FILE: design/sbmq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read port.
// Self-contained; used for every store of the queue manager.
module sbmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/shared_buffer_multi_queue_top.sv
`timescale 1ns / 1ps
// Top level of the shared-buffer multi-queue manager: control sequencer and stores.
// Depends on sbmq_pkg and sbmq_ram.
//
//   channel   handshake              payload
//   request   start, busy            request (req_t)
//   result    done (one-cycle pulse) result  (rsp_t)
//
// An enqueue is answered after the read of the queue table, a dequeue after the table read
// followed by the read of the head slot.
// A dequeue that finds its queue empty ends after the table read.
// The next request is taken in the cycle the result is shown.
// After reset the queue table is cleared one entry a cycle, with busy high.
// Results cannot be stalled; each one is shown for exactly one cycle.
module shared_buffer_multi_queue_top #(
	parameter int SLOTS      = sbmq_pkg::SLOTS_DEF,
	parameter int QUEUES     = sbmq_pkg::QUEUES_DEF,
	parameter int DATA_WIDTH = sbmq_pkg::DATA_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  sbmq_pkg::req_t request,
	output logic          done,
	output sbmq_pkg::rsp_t result
);
	import sbmq_pkg::*;

	localparam int PW  = $clog2(SLOTS + 1);
	localparam int SAW = $clog2(SLOTS);
	localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int IW  = (QW > 3) ? QW : 3;
	localparam logic [PW-1:0] NIL = PW'(SLOTS);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_POP
	} state_t;

	state_t                 state_q;
	logic [QW-1:0]          clr_cnt_q;
	cmd_t                   cmd_q;
	logic [QW-1:0]          qaddr_q;
	logic                   qvalid_q;
	logic [DATA_WIDTH-1:0]  value_q;
	logic [PW-1:0]          free_head_q;
	logic [PW-1:0]          fresh_q;
	logic                   fresh_rd_q;
	logic                   done_q;
	rsp_t                   rsp_q;

	logic                   accept;
	logic [IW-1:0]          qx;
	logic                   qvalid;
	logic signed [63:0]     val64;

	logic                   tbl_we, tbl_re;
	logic [QW-1:0]          tbl_waddr, tbl_raddr;
	logic [2*PW-1:0]        tbl_wdata, tbl_rdata;
	logic                   lnk_we, lnk_re;
	logic [SAW-1:0]         lnk_waddr, lnk_raddr;
	logic [PW-1:0]          lnk_wdata, lnk_rdata;
	logic                   dat_we, dat_re;
	logic [DATA_WIDTH-1:0]  dat_rdata;

	logic [PW-1:0]          head, tail, link_addr, link_eff, nx;
	logic                   head_nil, tail_nil, fh_nil, nx_nil, nf_nil, q_empty;
	logic signed [DATA_WIDTH-1:0] rd_s;
	logic signed [63:0]     rd64;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign qx     = IW'(request.queue_id);
	assign qvalid = 32'(request.queue_id) < 32'(QUEUES);
	assign val64  = 64'(request.value);

	assign head      = tbl_rdata[2*PW-1:PW];
	assign tail      = tbl_rdata[PW-1:0];
	assign head_nil  = head >= NIL;
	assign tail_nil  = tail >= NIL;
	assign q_empty   = head_nil || tail_nil;
	assign fh_nil    = free_head_q >= NIL;
	assign link_addr = (state_q == ST_POP) ? head : free_head_q;
	assign link_eff  = fresh_rd_q ? PW'(link_addr + PW'(1)) : lnk_rdata;
	assign nx        = (head == tail) ? NIL : link_eff;
	assign nx_nil    = nx >= NIL;
	assign nf_nil    = link_eff >= NIL;
	assign rd_s      = dat_rdata;
	assign rd64      = 64'(rd_s);

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = qaddr_q;
		tbl_wdata = {NIL, NIL};
		tbl_re    = accept;
		tbl_raddr = qx[QW-1:0];
		lnk_we    = 1'b0;
		lnk_waddr = tail[SAW-1:0];
		lnk_wdata = free_head_q;
		lnk_re    = 1'b0;
		lnk_raddr = free_head_q[SAW-1:0];
		dat_we    = 1'b0;
		dat_re    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				tbl_we    = 1'b1;
				tbl_waddr = clr_cnt_q;
			end
			ST_IDLE: begin
				lnk_re = accept;
			end
			ST_LOOK: begin
				if (cmd_q == CMD_ENQ) begin
					if (qvalid_q && !fh_nil) begin
						dat_we    = 1'b1;
						tbl_we    = 1'b1;
						tbl_wdata = {q_empty ? free_head_q : head, free_head_q};
						lnk_we    = !q_empty;
					end
				end else begin
					lnk_re    = 1'b1;
					dat_re    = 1'b1;
					lnk_raddr = head[SAW-1:0];
				end
			end
			ST_POP: begin
				tbl_we    = 1'b1;
				tbl_wdata = {nx_nil ? NIL : nx, nx_nil ? NIL : tail};
				lnk_we    = 1'b1;
				lnk_waddr = head[SAW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			free_head_q <= '0;
			fresh_q     <= '0;
			fresh_rd_q  <= 1'b0;
			done_q      <= 1'b0;
			cmd_q       <= CMD_ENQ;
			qaddr_q     <= '0;
			qvalid_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + QW'(1);
					if (clr_cnt_q == QW'(QUEUES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cmd_q      <= request.command;
						qaddr_q    <= qx[QW-1:0];
						qvalid_q   <= qvalid;
						value_q    <= val64[DATA_WIDTH-1:0];
						fresh_rd_q <= free_head_q >= fresh_q;
						state_q    <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (cmd_q == CMD_ENQ) begin
						done_q            <= 1'b1;
						rsp_q.data_out    <= '0;
						state_q           <= ST_IDLE;
						if (!qvalid_q || fh_nil) begin
							rsp_q.status      <= STAT_FULL;
							rsp_q.queue_empty <= !qvalid_q || head_nil;
							rsp_q.store_full  <= fh_nil;
						end else begin
							rsp_q.status      <= STAT_DONE;
							rsp_q.queue_empty <= 1'b0;
							rsp_q.store_full  <= nf_nil;
							free_head_q       <= link_eff;
							if (fresh_rd_q) begin
								fresh_q <= PW'(free_head_q + PW'(1));
							end
						end
					end else if (!qvalid_q || head_nil) begin
						done_q            <= 1'b1;
						rsp_q.data_out    <= -32'sd1;
						rsp_q.status      <= STAT_EMPTY;
						rsp_q.queue_empty <= 1'b1;
						rsp_q.store_full  <= fh_nil;
						state_q           <= ST_IDLE;
					end else begin
						fresh_rd_q <= head >= fresh_q;
						state_q    <= ST_POP;
					end
				end
				ST_POP: begin
					done_q            <= 1'b1;
					rsp_q.data_out    <= rd64[31:0];
					rsp_q.status      <= STAT_DONE;
					rsp_q.queue_empty <= nx_nil;
					rsp_q.store_full  <= 1'b0;
					free_head_q       <= head;
					state_q           <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

	sbmq_ram #(.WIDTH(2 * PW), .DEPTH(QUEUES), .AW(QW)) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	sbmq_ram #(.WIDTH(PW), .DEPTH(SLOTS), .AW(SAW)) u_link (
		.clk   (clk),
		.we    (lnk_we),
		.waddr (lnk_waddr),
		.wdata (lnk_wdata),
		.re    (lnk_re),
		.raddr (lnk_raddr),
		.rdata (lnk_rdata)
	);

	sbmq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS), .AW(SAW)) u_data (
		.clk   (clk),
		.we    (dat_we),
		.waddr (free_head_q[SAW-1:0]),
		.wdata (value_q),
		.re    (dat_re),
		.raddr (head[SAW-1:0]),
		.rdata (dat_rdata)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transfer did not raise busy");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NIL)
		else $error("fresh slot count beyond store size");

	a_pop_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> !head_nil && (head < fresh_q))
		else $error("dequeue of a slot that was never allocated");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for shared_buffer_multi_queue_top.
// Depends on sbmq_pkg and the design files; a scoreboard class predicts every result.
module testbench;
	import sbmq_pkg::*;

	localparam int SLOTS      = SLOTS_DEF;
	localparam int QUEUES     = QUEUES_DEF;
	localparam int PW         = $clog2(SLOTS + 1);
	localparam logic [PW-1:0] NIL = PW'(SLOTS);
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 400;

	typedef enum {
		PH_FILL,
		PH_DRAIN,
		PH_MIX
	} phase_t;

	class queue_scoreboard;
		logic [31:0]   slot_data [SLOTS];
		logic [PW-1:0] slot_link [SLOTS];
		logic [PW-1:0] queue_head [QUEUES];
		logic [PW-1:0] queue_tail [QUEUES];
		logic [PW-1:0] free_head;
		int            depth [QUEUES];
		int            used;
		rsp_t          pending_q [$];
		int            errors;
		int            enq_count;
		int            drop_count;
		int            deq_count;
		int            empty_count;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				slot_data[i] = '0;
				slot_link[i] = (i == SLOTS - 1) ? NIL : PW'(i + 1);
			end
			for (int i = 0; i < QUEUES; i++) begin
				queue_head[i] = NIL;
				queue_tail[i] = NIL;
				depth[i] = 0;
			end
			free_head = '0;
			used = 0;
			errors = 0;
			enq_count = 0;
			drop_count = 0;
			deq_count = 0;
			empty_count = 0;
		endfunction

		function void note_request(req_t r);
			rsp_t          e;
			int            q;
			logic [PW-1:0] fh;
			logic [PW-1:0] h;
			logic [PW-1:0] nx;
			e.data_out = '0;
			e.status = STAT_DONE;
			e.queue_empty = 1'b1;
			q = r.queue_id;
			if (q >= QUEUES) begin
				if (r.command == CMD_ENQ) begin
					e.status = STAT_FULL;
				end else begin
					e.data_out = -1;
					e.status = STAT_EMPTY;
				end
			end else if (r.command == CMD_ENQ) begin
				enq_count++;
				fh = free_head;
				if (fh == NIL) begin
					e.status = STAT_FULL;
					drop_count++;
				end else begin
					free_head = slot_link[fh];
					if (queue_head[q] == NIL || queue_tail[q] == NIL) begin
						queue_head[q] = fh;
					end else begin
						slot_link[queue_tail[q]] = fh;
					end
					queue_tail[q] = fh;
					slot_data[fh] = r.value;
					slot_link[fh] = NIL;
					depth[q]++;
					used++;
				end
				e.queue_empty = (queue_head[q] == NIL);
			end else begin
				h = queue_head[q];
				if (h == NIL) begin
					e.data_out = -1;
					e.status = STAT_EMPTY;
					empty_count++;
				end else begin
					nx = slot_link[h];
					queue_head[q] = nx;
					if (nx == NIL) begin
						queue_tail[q] = NIL;
					end
					slot_link[h] = free_head;
					free_head = h;
					e.data_out = slot_data[h];
					depth[q]--;
					used--;
					deq_count++;
				end
				e.queue_empty = (queue_head[q] == NIL);
			end
			e.store_full = (free_head == NIL);
			pending_q.push_back(e);
		endfunction

		function void check_result(rsp_t a);
			rsp_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, a);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (a.data_out !== e.data_out) begin
				$display("%0t: data_out mismatch, expected %h, actual %h",
					$time, e.data_out, a.data_out);
				errors++;
			end
			if (a.status !== e.status) begin
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, e.status, a.status);
				errors++;
			end
			if (a.queue_empty !== e.queue_empty) begin
				$display("%0t: queue_empty mismatch, expected %b, actual %b",
					$time, e.queue_empty, a.queue_empty);
				errors++;
			end
			if (a.store_full !== e.store_full) begin
				$display("%0t: store_full mismatch, expected %b, actual %b",
					$time, e.store_full, a.store_full);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	rsp_t result;

	queue_scoreboard sb;
	int              cycle_count = 0;

	shared_buffer_multi_queue_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				sb.check_result(result);
			end
			if (start && !busy) begin
				sb.note_request(request);
			end
		end
	end

	function automatic req_t make_request(cmd_t c, int q, logic [31:0] v);
		req_t r;
		r.command = c;
		r.queue_id = 3'(q);
		r.value = v;
		return r;
	endfunction

	task automatic send_request(req_t r);
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_cycles(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] random_value();
		if ($urandom_range(0, 15) == 0) begin
			case ($urandom_range(0, 3))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h7FFF_FFFF;
				default: return 32'h8000_0000;
			endcase
		end
		return $urandom;
	endfunction

	function automatic req_t random_request(phase_t ph);
		int enq_pct;
		int live [$];
		int q;
		case (ph)
			PH_FILL: enq_pct = 98;
			PH_DRAIN: enq_pct = 5;
			default: enq_pct = 50;
		endcase
		if ($urandom_range(0, 99) < enq_pct) begin
			return make_request(CMD_ENQ, $urandom_range(0, QUEUES - 1), random_value());
		end
		for (int i = 0; i < QUEUES; i++) begin
			if (sb.depth[i] > 0) live.push_back(i);
		end
		if (live.size() > 0 && $urandom_range(0, 99) < 85) begin
			q = live[$urandom_range(0, live.size() - 1)];
		end else begin
			q = $urandom_range(0, QUEUES - 1);
		end
		return make_request(CMD_DEQ, q, $urandom);
	endfunction

	initial begin
		phase_t ph;
		int     burst_left;
		int     drops_at_full;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_request(make_request(CMD_DEQ, 0, 32'h1234_5678));
		send_request(make_request(CMD_ENQ, 0, 32'h7FFF_FFFF));
		send_request(make_request(CMD_ENQ, 7, 32'h8000_0000));
		send_request(make_request(CMD_ENQ, 3, 32'h0000_0000));
		send_request(make_request(CMD_ENQ, 3, 32'hFFFF_FFFF));
		send_request(make_request(CMD_ENQ, 3, 32'hA5A5_5A5A));
		send_request(make_request(CMD_DEQ, 0, 32'hFFFF_FFFF));
		send_request(make_request(CMD_DEQ, 0, 32'h0000_0000));
		send_request(make_request(CMD_DEQ, 7, 32'h0000_0000));
		send_request(make_request(CMD_DEQ, 3, 32'h0000_0000));
		idle_cycles(3);
		send_request(make_request(CMD_DEQ, 3, 32'h0000_0000));
		send_request(make_request(CMD_DEQ, 3, 32'h0000_0000));
		send_request(make_request(CMD_DEQ, 3, 32'h0000_0000));
		for (int i = 0; i < QUEUES; i++) begin
			send_request(make_request(CMD_ENQ, i, 32'h5A5A_A5A5 ^ i));
		end
		send_request(make_request(CMD_DEQ, 1, 32'h0000_0000));
		send_request(make_request(CMD_DEQ, 6, 32'h0000_0000));
		wait_drained();

		ph = PH_FILL;
		burst_left = 0;
		drops_at_full = 0;
		for (int n = 0; n < RANDOM_ITEMS || ph != PH_MIX; n++) begin
			if (burst_left == 0) begin
				idle_cycles($urandom_range(0, 6));
				burst_left = ($urandom_range(0, 7) == 0) ?
					$urandom_range(40, 80) : $urandom_range(1, 20);
			end
			burst_left--;
			if (n == RANDOM_ITEMS / 2) begin
				wait_drained();
			end
			send_request(random_request(ph));
			if (ph == PH_FILL && sb.used == SLOTS) begin
				drops_at_full++;
				if (drops_at_full > 6) ph = PH_DRAIN;
			end else if (ph == PH_DRAIN && sb.used <= SLOTS / 2) begin
				ph = PH_MIX;
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.pending_q.size() != 0) begin
			$display("%0d results never arrived", sb.pending_q.size());
			sb.errors++;
		end
		$display("Covered %0d enqueues (%0d dropped on a full store) and %0d dequeues",
			sb.enq_count, sb.drop_count, sb.deq_count + sb.empty_count);
		$display("(%0d of them from empty queues), with %0d mismatches.",
			sb.empty_count, sb.errors);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
